// ===== rtl/madtp_pkg.sv =====
package madtp_pkg;

  // Capacity of each record kind
  localparam int MAX_PROCESSORS = 256;
  localparam int MAX_IO_APICS   = 8;
  localparam int MAX_OVERRIDES  = 16;

  localparam int PROC_CNT_W = $clog2(MAX_PROCESSORS + 1);
  localparam int IOA_CNT_W  = $clog2(MAX_IO_APICS + 1);
  localparam int OVR_CNT_W  = $clog2(MAX_OVERRIDES + 1);

  // Table layout
  localparam int          HDR_BYTES = 44;
  localparam int          SUB_KEEP  = 16;
  localparam logic [31:0] LEN_LO    = 32'd4;
  localparam logic [31:0] LEN_HI    = 32'd7;
  localparam logic [31:0] MIN_LEN   = 32'd8;

  // Subtable type codes
  localparam logic [7:0] SUB_LAPIC    = 8'd0;
  localparam logic [7:0] SUB_IOAPIC   = 8'd1;
  localparam logic [7:0] SUB_OVERRIDE = 8'd2;
  localparam logic [7:0] SUB_X2APIC   = 8'd9;

  // Event queue between front and back
  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
  localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PROC     = 2'd0,
    KIND_IOAPIC   = 2'd1,
    KIND_OVERRIDE = 2'd2,
    KIND_END      = 2'd3
  } madtp_kind_e;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       first_byte;
  } madtp_in_t;

  typedef struct packed {
    madtp_kind_e record_kind;
    logic [7:0]  entry_index;
    logic [31:0] apic_id;
    logic [31:0] processor_uid;
    logic [31:0] global_irq;
    logic [7:0]  irq_source;
    logic        level_sensitive;
    logic        active_low;
    logic        checksum_ok;
    logic        malformed;
    logic        last_in_run;
  } madtp_rec_t;

  // What the front hands to the back for one byte
  typedef struct packed {
    logic       has_sub;
    madtp_rec_t sub_rec;
    logic       has_end;
    logic       checksum_ok;
    logic       malformed;
  } madtp_ev_t;

endpackage

// ===== rtl/madtp_front.sv =====
module madtp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  madtp_pkg::madtp_in_t item_i,
  output logic                 ev_push_o,
  output madtp_pkg::madtp_ev_t ev_o
);
  import madtp_pkg::*;

  logic [31:0]          off_q, off_d, len_q, len_d;
  logic [7:0]           sum_q, sum_d, sub_q, sub_d;
  logic                 ws_q, ws_d;
  logic [PROC_CNT_W-1:0] proc_cnt_q, proc_cnt_d;
  logic [IOA_CNT_W-1:0]  ioa_cnt_q, ioa_cnt_d;
  logic [OVR_CNT_W-1:0]  ovr_cnt_q, ovr_cnt_d;
  logic [7:0]           sb_q [SUB_KEEP];
  logic [7:0]           cur  [SUB_KEEP];

  logic [31:0] eff_off, eff_len, len_new;
  logic [7:0]  eff_sum, eff_sub, b, sum_new;
  logic        eff_ws, active, walk, bad, done, is_end;
  logic [31:0] flags, apic, uid, le4, le8, le12;
  logic        is_proc, is_ioa, is_ovr, proc_ok, ioa_ok, ovr_ok;

  always_comb begin
    b       = item_i.table_byte;
    eff_off = item_i.first_byte ? '0 : off_q;
    eff_len = item_i.first_byte ? '0 : len_q;
    eff_sum = item_i.first_byte ? '0 : sum_q;
    eff_sub = item_i.first_byte ? '0 : sub_q;
    eff_ws  = item_i.first_byte ? 1'b0 : ws_q;

    active  = (eff_off < MIN_LEN) || (eff_off < eff_len);
    sum_new = eff_sum + b;
    len_new = eff_len;
    if (eff_off >= LEN_LO && eff_off <= LEN_HI) begin
      len_new = eff_len | ({24'd0, b} << {eff_off[1:0], 3'd0});
    end

    walk = active && (eff_off >= 32'(HDR_BYTES)) && !eff_ws;

    // subtable bytes as they stand after this byte
    for (int i = 0; i < SUB_KEEP; i++) begin
      if (eff_sub == 8'd0) begin
        cur[i] = (i == 0) ? b : 8'd0;
      end else if (eff_sub == 8'(i)) begin
        cur[i] = b;
      end else begin
        cur[i] = sb_q[i];
      end
    end

    bad  = walk && (eff_sub == 8'd1) && (b < 8'd2);
    done = walk && !bad && (eff_sub != 8'd0) &&
           ({1'b0, eff_sub} + 9'd1 == {1'b0, cur[1]});

    le4  = {cur[7], cur[6], cur[5], cur[4]};
    le8  = {cur[11], cur[10], cur[9], cur[8]};
    le12 = {cur[15], cur[14], cur[13], cur[12]};

    is_proc = (cur[0] == SUB_LAPIC) || (cur[0] == SUB_X2APIC);
    is_ioa  = (cur[0] == SUB_IOAPIC);
    is_ovr  = (cur[0] == SUB_OVERRIDE);
    flags   = (cur[0] == SUB_LAPIC) ? le4 : le8;
    apic    = (cur[0] == SUB_LAPIC) ? {24'd0, cur[3]} : le4;
    uid     = (cur[0] == SUB_LAPIC) ? {24'd0, cur[2]} : le12;

    proc_ok = done && is_proc && (flags == 32'd1) &&
              (proc_cnt_q < PROC_CNT_W'(MAX_PROCESSORS));
    ioa_ok  = done && is_ioa && (ioa_cnt_q < IOA_CNT_W'(MAX_IO_APICS));
    ovr_ok  = done && is_ovr && (ovr_cnt_q < OVR_CNT_W'(MAX_OVERRIDES));

    is_end = active && (eff_off >= LEN_HI) &&
             ({1'b0, eff_off} + 33'd1 >= {1'b0, len_new});

    ev_o         = '0;
    ev_o.has_sub = proc_ok || ioa_ok || ovr_ok;
    if (proc_ok) begin
      ev_o.sub_rec.record_kind   = KIND_PROC;
      ev_o.sub_rec.entry_index   = 8'(proc_cnt_q);
      ev_o.sub_rec.apic_id       = apic;
      ev_o.sub_rec.processor_uid = uid;
    end else if (ioa_ok) begin
      ev_o.sub_rec.record_kind = KIND_IOAPIC;
      ev_o.sub_rec.entry_index = 8'(ioa_cnt_q);
      ev_o.sub_rec.global_irq  = le8;
    end else begin
      ev_o.sub_rec.record_kind     = KIND_OVERRIDE;
      ev_o.sub_rec.entry_index     = 8'(ovr_cnt_q);
      ev_o.sub_rec.global_irq      = le4;
      ev_o.sub_rec.irq_source      = cur[3];
      ev_o.sub_rec.level_sensitive = cur[8][3];
      ev_o.sub_rec.active_low      = cur[8][1];
    end
    ev_o.has_end     = is_end;
    ev_o.checksum_ok = (sum_new == 8'd0);
    ev_o.malformed   = eff_ws || bad;

    ev_push_o = accept_i && (ev_o.has_sub || is_end);

    // next state
    off_d = (eff_off == '1) ? eff_off : eff_off + 32'd1;
    len_d = active ? len_new : eff_len;
    sum_d = active ? sum_new : eff_sum;
    ws_d  = eff_ws || bad;
    if (!walk) begin
      sub_d = eff_sub;
    end else if (bad || done) begin
      sub_d = 8'd0;
    end else begin
      sub_d = eff_sub + 8'd1;
    end
    proc_cnt_d = proc_cnt_q + PROC_CNT_W'(proc_ok);
    ioa_cnt_d  = ioa_cnt_q + IOA_CNT_W'(ioa_ok);
    ovr_cnt_d  = ovr_cnt_q + OVR_CNT_W'(ovr_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      sub_q      <= '0;
      ws_q       <= 1'b0;
      proc_cnt_q <= '0;
      ioa_cnt_q  <= '0;
      ovr_cnt_q  <= '0;
    end else if (accept_i) begin
      off_q      <= off_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      sub_q      <= sub_d;
      ws_q       <= ws_d;
      proc_cnt_q <= proc_cnt_d;
      ioa_cnt_q  <= ioa_cnt_d;
      ovr_cnt_q  <= ovr_cnt_d;
    end
  end

  // capture of the current subtable's leading bytes
  always_ff @(posedge clk_i) begin
    if (accept_i && walk) begin
      for (int i = 0; i < SUB_KEEP; i++) begin
        sb_q[i] <= cur[i];
      end
    end
  end

endmodule

// ===== rtl/madtp_evq.sv =====
module madtp_evq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  madtp_pkg::madtp_ev_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output madtp_pkg::madtp_ev_t data_o
);
  import madtp_pkg::*;

  madtp_ev_t            mem_q [EVQ_DEPTH];
  logic [EVQ_PTR_W-1:0] wr_q, rd_q;
  logic [EVQ_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == EVQ_CNT_W'(EVQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + EVQ_CNT_W'(push_i) - EVQ_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/madtp_back.sv =====
module madtp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ev_empty_i,
  input  madtp_pkg::madtp_ev_t  ev_i,
  output logic                  ev_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output madtp_pkg::madtp_rec_t result_o
);
  import madtp_pkg::*;

  madtp_rec_t out_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       phase_q;

  logic       pop_acc, space, emit_sub, out_push;
  madtp_rec_t rec;

  always_comb begin
    pop_acc  = pop_i && !empty_o;
    space    = (cnt_q != 2'd2) || pop_acc;
    emit_sub = !ev_empty_i && ev_i.has_sub && !phase_q;
    out_push = !ev_empty_i && space;
    ev_pop_o = out_push && (!emit_sub || !ev_i.has_end);

    if (emit_sub) begin
      rec             = ev_i.sub_rec;
      rec.last_in_run = !ev_i.has_end;
    end else begin
      rec             = '0;
      rec.record_kind = KIND_END;
      rec.checksum_ok = ev_i.checksum_ok;
      rec.malformed   = ev_i.malformed;
      rec.last_in_run = 1'b1;
    end
  end

  assign empty_o  = (cnt_q == 2'd0);
  assign result_o = out_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= 2'd0;
      phase_q <= 1'b0;
    end else begin
      if (out_push) begin
        wr_q <= !wr_q;
      end
      if (pop_acc) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(out_push) - 2'(pop_acc);
      if (ev_pop_o) begin
        phase_q <= 1'b0;
      end else if (out_push && emit_sub) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q[wr_q] <= rec;
    end
  end

  // second half of a two-record event only while that event is at the head
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!ev_empty_i && ev_i.has_sub && ev_i.has_end))
    else $error("phase set without a two-record event");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop_acc) |=> (cnt_q == 2'd2))
    else $error("output buffer written while full");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_pop_o |-> rec.last_in_run)
    else $error("event retired before its last record");

endmodule

// ===== rtl/madt_subtable_parser.sv =====
// A byte that completes a record reaches the result side through the event queue
//   write, then the two-entry output buffer.
// Throughput: one byte per cycle while the event queue is not full; a byte yielding
//   two records holds the back end for both, which the four-entry queue absorbs.
// Reset (rst_ni, async, active low) clears offsets, sum, counts and all queues;
//   the subtable byte capture is not reset and is rewritten at each subtable start.
module madt_subtable_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  madtp_pkg::madtp_in_t  item_i,
  output logic                  empty,
  input  logic                  pop,
  output madtp_pkg::madtp_rec_t result_o
);
  import madtp_pkg::*;

  logic      accept;
  logic      ev_push, ev_pop, ev_empty;
  madtp_ev_t ev_in, ev_out;

  // Front takes a byte whenever the event queue has room; every byte is
  // consumed in its cycle, only bytes that yield records push an event.
  assign accept = push && !full;

  madtp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item_i),
    .ev_push_o (ev_push),
    .ev_o      (ev_in)
  );

  madtp_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_in),
    .full_o  (full),
    .pop_i   (ev_pop),
    .empty_o (ev_empty),
    .data_o  (ev_out)
  );

  // Back expands each event into one or two result items
  madtp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_empty_i (ev_empty),
    .ev_i       (ev_out),
    .ev_pop_o   (ev_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result_o)
  );

endmodule
